// ===== rtl/ahcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ahcc_pkg
// Shared widths, register codes and interface types for the additive hash
// collision counter and its remainder unit.
// ----------------------------------------------------------------------------
package ahcc_pkg;

   localparam int SUM_W    = 31;
   localparam int CODE_W   = 8;
   localparam int SIZE_W   = 17;
   localparam int COUNT_W  = 17;
   localparam int BUCKET_W = 16;
   localparam int HIT_W    = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam int DEFAULT_TABLE_DEPTH = 65536;

   localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic [HIT_W-1:0]   HIT_MAX    = {HIT_W{1'b1}};
   localparam logic [HIT_W-1:0]   HIT_PAIR   = HIT_W'(2);
   localparam logic [SUM_W-1:0]   BASE_RESET = SUM_W'(5003);
   localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(5000);

   // register select is the word address, paddr[2]
   localparam logic REG_HASH_BASE  = 1'b0;
   localparam logic REG_TABLE_SIZE = 1'b1;

   localparam logic MODE_CHAR  = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   // remainder unit: one dividend bit per cycle
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [SUM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] rem;
   } div_rsp_type;

endpackage

// ===== rtl/additive_hash_collision_counter.sv =====
// ----------------------------------------------------------------------------
// A character that does not end a word is summed without leaving the idle state;
// a word end gives its result strobe after two 31-step remainder passes through
// one shared unit, then a bucket read and a write back. busy drops with the
// strobe, so a word end holds the request channel until its strobe.
// A clear request, and reset, run a clearing pass over every entry of the bucket
// store with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
// additive_hash_collision_counter
// Sums character codes per word, hashes the sum to a bucket by two moduli and
// counts buckets that have been hit at least twice.
// ----------------------------------------------------------------------------
module additive_hash_collision_counter
   import ahcc_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [CODE_W-1:0]   req_char_code,
   input  logic                req_end_of_word,
   // result channel
   output logic                rsp_valid,
   output logic [BUCKET_W-1:0] rsp_bucket,
   output logic [COUNT_W-1:0]  rsp_collision_total,
   // configuration
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CSR_AW-1:0]   paddr,
   input  logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]   prdata,
   output logic                pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [31:0]      DEPTH_32 = 32'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_BASE,
      S_DIV_SIZE,
      S_READ,
      S_UPDATE
   } state_type;

   state_type            state_ff, state_in;
   logic [SUM_W-1:0]     base_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HIT_W-1:0]     hits_rd_ff;
   logic [HIT_W-1:0]     hits_mem [TABLE_DEPTH];

   logic                 accept;
   logic                 csr_wr;
   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_sat;
   logic [SUM_W-1:0]     base_eff;
   logic [31:0]          size_eff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [HIT_W-1:0]     mem_wdata;
   logic [HIT_W-1:0]     hits_next;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
         size_ff <= SIZE_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_HASH_BASE:  base_ff <= pwdata[SUM_W-1:0];
            REG_TABLE_SIZE: size_ff <= pwdata[SIZE_W-1:0];
            default:        base_ff <= base_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_HASH_BASE:  prdata = CSR_DW'(base_ff);
         REG_TABLE_SIZE: prdata = CSR_DW'(size_ff);
         default:        prdata = '0;
      endcase
   end

   assign base_eff = (base_ff == '0) ? SUM_W'(1) : base_ff;

   always_comb begin
      if (size_ff == '0) begin
         size_eff = 32'd1;
      end else if (32'(size_ff) > DEPTH_32) begin
         size_eff = DEPTH_32;
      end else begin
         size_eff = 32'(size_ff);
      end
   end

   // ------------------------------------------------------------------
   // shared remainder unit
   // ------------------------------------------------------------------
   ahcc_rem_unit u_rem (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start & ~busy;
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(req_char_code);
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign hits_next = (hits_rd_ff == HIT_MAX) ? HIT_MAX : hits_rd_ff + HIT_W'(1);

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      div_req      = '0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = hits_next;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_CLEAR) begin
                  count_in = '0;
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else if (req_end_of_word) begin
                  sum_in           = '0;
                  div_req.start    = 1'b1;
                  div_req.dividend = sum_sat;
                  div_req.divisor  = base_eff;
                  state_in         = S_DIV_BASE;
               end else begin
                  sum_in = sum_sat;
               end
            end
         end
         S_DIV_BASE: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.rem;
               div_req.divisor  = SUM_W'(size_eff);
               state_in         = S_DIV_SIZE;
            end
         end
         S_DIV_SIZE: begin
            if (div_rsp.done) begin
               idx_in   = div_rsp.rem[IDX_W-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            mem_we = 1'b1;
            // count a bucket exactly once, when it takes its second hit
            if (hits_rd_ff != HIT_MAX && hits_next == HIT_PAIR && count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sum_ff       <= '0;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
   end

   // bucket hit store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hits_mem[mem_waddr] <= mem_wdata;
      end
      hits_rd_ff <= hits_mem[idx_ff];
   end

   // result registers; the strobe follows the update cycle
   logic [BUCKET_W-1:0] bucket_ff;
   logic [COUNT_W-1:0]  total_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         bucket_ff <= BUCKET_W'(idx_ff);
         total_ff  <= count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bucket          = bucket_ff;
   assign rsp_collision_total = total_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !div_rsp.busy)
      else $error("remainder unit active while block is idle");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_CLEAR) |=> busy)
      else $error("clear request did not start clearing pass");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> (32'(idx_ff) < size_eff))
      else $error("bucket index outside table");

endmodule

// ===== rtl/ahcc_rem_unit.sv =====
// ----------------------------------------------------------------------------
// ahcc_rem_unit
// Restoring remainder unit, one dividend bit per cycle. Divisor must be
// nonzero. done pulses for one cycle with rem valid.
// ----------------------------------------------------------------------------
module ahcc_rem_unit
   import ahcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [SUM_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SUM_W:0]       trial;
   logic [SUM_W:0]       diff;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // trial < 2*divisor, so one conditional subtract restores the range
         rem_in = diff[SUM_W] ? trial[SUM_W-1:0] : diff[SUM_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule
